[rtl/core/ucdt_pkg.sv]
// Constants and helper functions shared by the Unix-time to civil-date pipeline.
package ucdt_pkg;

    localparam int NUM_STAGES = 7;

    // floor(x / 675) = (x * DAY_RECIP) >> 35 for any 25-bit x.
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [32:0] SECS_PER_DAY  = 33'd86400;
    localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
    localparam logic [19:0] ERA4_START    = 20'd584388;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [17:0] DAYS_PER_ERA_M1 = 18'd146096;

    // floor(x / 365) = (x * DIV365_RECIP) >> 26 for any 18-bit x.
    localparam logic [17:0] DIV365_RECIP  = 18'd183860;
    // floor(x / 225) = (x * DIV225_RECIP) >> 22 for any 13-bit x.
    localparam logic [27:0] DIV225_RECIP  = 28'd18642;
    // floor(x / 15) = (x * DIV15_RECIP) >> 20 for any 15-bit x.
    localparam logic [31:0] DIV15_RECIP   = 32'd69906;
    // floor(x / 153) = (x * DIV153_RECIP) >> 18 for any 11-bit x.
    localparam logic [21:0] DIV153_RECIP  = 22'd1714;

    localparam logic [11:0] ERA4_YEAR     = 12'd1600;
    localparam logic [11:0] ERA5_YEAR     = 12'd2000;

    function automatic logic [8:0] div365(input logic [17:0] x);
        logic [35:0] prod;
        prod = 36'(x) * 36'(DIV365_RECIP);
        return prod[34:26];
    endfunction

    // Day of the March-based year on which month index mp starts.
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] offs;
        case (mp)
            4'd0:    offs = 9'd0;
            4'd1:    offs = 9'd31;
            4'd2:    offs = 9'd61;
            4'd3:    offs = 9'd92;
            4'd4:    offs = 9'd122;
            4'd5:    offs = 9'd153;
            4'd6:    offs = 9'd184;
            4'd7:    offs = 9'd214;
            4'd8:    offs = 9'd245;
            4'd9:    offs = 9'd275;
            4'd10:   offs = 9'd306;
            4'd11:   offs = 9'd337;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

[rtl/core/unix_seconds_to_civil_datetime_unit.sv]
// Seven-stage pipeline that converts Unix seconds to year, month, day, hour and minute.
//
// A request carries one unsigned 32-bit seconds count on unix_seconds with
// req_valid; it is taken on a rising edge where req_valid is high and
// req_stall is low. Each request yields exactly one result on year, month,
// day, hour and minute, offered with rsp_valid and taken when rsp_stall is low.
// Seconds within the minute are discarded.
// One request can enter every cycle while req_stall is low. The rate is one
// request per cycle because each of the seven register stages can take new
// data at every edge on which it advances.
// Every stage moves forward when it is empty or the stage after it moves,
// so bubbles collapse; when the receiver stalls, results wait in their
// stages and req_stall rises only once all seven stages are full.
// An asynchronous low rst_n empties the pipeline; nothing else needs clearing.
module unix_seconds_to_civil_datetime_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [31:0] unix_seconds,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute
);
    import ucdt_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !rsp_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign req_stall = !adv[0];
    assign rsp_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: whole days.
    logic [50:0] day_prod;
    logic [31:0] s0_secs_reg;
    logic [15:0] s0_days_reg;

    assign day_prod = 51'(unix_seconds[31:7]) * 51'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_secs_reg <= unix_seconds;
            s0_days_reg <= day_prod[50:35];
        end
    end

    // Stage 1: time of day, era and day of era.
    logic [32:0] tod_full;
    logic [19:0] zd;
    logic        era_hi;
    logic [19:0] doe_full;
    logic [16:0] s1_tod_reg;
    logic [17:0] s1_doe_reg;
    logic        s1_era_reg;

    assign tod_full = {1'b0, s0_secs_reg} - 33'(s0_days_reg) * SECS_PER_DAY;
    assign zd       = 20'(s0_days_reg) + EPOCH_SHIFT;
    assign era_hi   = zd >= ERA5_START;
    assign doe_full = zd - (era_hi ? ERA5_START : ERA4_START);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_tod_reg <= tod_full[16:0];
            s1_doe_reg <= doe_full[17:0];
            s1_era_reg <= era_hi;
        end
    end

    // Stage 2: leap-corrected day count, hour and minutes of the day.
    logic [8:0]  q1460;
    logic [17:0] cent_cnt;
    logic [17:0] last_day;
    logic [17:0] leap_adj;
    logic [27:0] hour_prod;
    logic [31:0] mins_prod;
    logic [17:0] s2_adj_reg;
    logic [17:0] s2_doe_reg;
    logic        s2_era_reg;
    logic [4:0]  s2_hour_reg;
    logic [10:0] s2_mins_reg;

    assign q1460    = div365({2'b00, s1_doe_reg[17:2]});
    assign cent_cnt = 18'(s1_doe_reg >= 18'd36524) + 18'(s1_doe_reg >= 18'd73048)
                    + 18'(s1_doe_reg >= 18'd109572) + 18'(s1_doe_reg >= 18'd146096);
    assign last_day = 18'(s1_doe_reg == DAYS_PER_ERA_M1);
    assign leap_adj = s1_doe_reg - 18'(q1460) + cent_cnt - last_day;
    assign hour_prod = 28'(s1_tod_reg[16:4]) * DIV225_RECIP;
    assign mins_prod = 32'(s1_tod_reg[16:2]) * DIV15_RECIP;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_adj_reg  <= leap_adj;
            s2_doe_reg  <= s1_doe_reg;
            s2_era_reg  <= s1_era_reg;
            s2_hour_reg <= hour_prod[26:22];
            s2_mins_reg <= mins_prod[30:20];
        end
    end

    // Stage 3: year of era and minute of hour.
    logic [10:0] minute_full;
    logic [8:0]  s3_yoe_reg;
    logic [17:0] s3_doe_reg;
    logic        s3_era_reg;
    logic [4:0]  s3_hour_reg;
    logic [5:0]  s3_minute_reg;

    assign minute_full = s2_mins_reg - 11'(s2_hour_reg) * 11'd60;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_yoe_reg    <= div365(s2_adj_reg);
            s3_doe_reg    <= s2_doe_reg;
            s3_era_reg    <= s2_era_reg;
            s3_hour_reg   <= s2_hour_reg;
            s3_minute_reg <= minute_full[5:0];
        end
    end

    // Stage 4: day of the March-based year.
    logic [17:0] cent_y;
    logic [17:0] year_start;
    logic [17:0] doy_full;
    logic [8:0]  s4_doy_reg;
    logic [8:0]  s4_yoe_reg;
    logic        s4_era_reg;
    logic [4:0]  s4_hour_reg;
    logic [5:0]  s4_minute_reg;

    assign cent_y     = 18'(s3_yoe_reg >= 9'd100) + 18'(s3_yoe_reg >= 9'd200)
                      + 18'(s3_yoe_reg >= 9'd300);
    assign year_start = 18'(s3_yoe_reg) * 18'd365 + 18'(s3_yoe_reg[8:2]) - cent_y;
    assign doy_full   = s3_doe_reg - year_start;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_doy_reg    <= doy_full[8:0];
            s4_yoe_reg    <= s3_yoe_reg;
            s4_era_reg    <= s3_era_reg;
            s4_hour_reg   <= s3_hour_reg;
            s4_minute_reg <= s3_minute_reg;
        end
    end

    // Stage 5: month index counted from March.
    logic [10:0] mp_num;
    logic [21:0] mp_prod;
    logic [3:0]  s5_mp_reg;
    logic [8:0]  s5_doy_reg;
    logic [8:0]  s5_yoe_reg;
    logic        s5_era_reg;
    logic [4:0]  s5_hour_reg;
    logic [5:0]  s5_minute_reg;

    assign mp_num  = 11'(s4_doy_reg) * 11'd5 + 11'd2;
    assign mp_prod = 22'(mp_num) * DIV153_RECIP;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_mp_reg     <= mp_prod[21:18];
            s5_doy_reg    <= s4_doy_reg;
            s5_yoe_reg    <= s4_yoe_reg;
            s5_era_reg    <= s4_era_reg;
            s5_hour_reg   <= s4_hour_reg;
            s5_minute_reg <= s4_minute_reg;
        end
    end

    // Stage 6: calendar month, day and year, with hour and minute, into the output registers.
    logic [8:0]  day_full;
    logic [3:0]  month_next;
    logic [11:0] year_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;

    assign day_full   = s5_doy_reg - month_offset(s5_mp_reg) + 9'd1;
    assign month_next = (s5_mp_reg < 4'd10) ? (s5_mp_reg + 4'd3) : (s5_mp_reg - 4'd9);
    assign year_next  = 12'(s5_yoe_reg) + (s5_era_reg ? ERA5_YEAR : ERA4_YEAR)
                      + 12'(month_next <= 4'd2);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_full[4:0];
            hour_reg   <= s5_hour_reg;
            minute_reg <= s5_minute_reg;
        end
    end

    assign year   = year_reg;
    assign month  = month_reg;
    assign day    = day_reg;
    assign hour   = hour_reg;
    assign minute = minute_reg;

`ifndef NO_ASSERTIONS
    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&valid_reg))
        else $error("request stalled while the pipeline has an empty stage");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (hour <= 5'd23 && minute <= 6'd59))
        else $error("hour or minute out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (year >= 12'd1970 && year <= 12'd2106))
        else $error("year out of range");
`endif

endmodule

[bench/unix_seconds_to_civil_datetime_unit_tb.sv]
// Testbench for the Unix-seconds to civil date and time pipeline, checked by a predictor.
`timescale 1ns / 100ps

typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
} civil_stamp_t;

class civil_date_ledger;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned EPOCH_SHIFT   = 719468;
    localparam int unsigned DAYS_PER_ERA  = 146097;

    civil_stamp_t due_dates[$];
    logic [31:0]  due_secs[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    function civil_stamp_t civil_from_seconds(logic [31:0] secs);
        int unsigned days, tod, zd, era, doe, yoe, yr, doy, mp, dd, mm;
        civil_stamp_t stamp;
        days = secs / SECS_PER_DAY;
        tod  = secs % SECS_PER_DAY;
        zd   = days + EPOCH_SHIFT;
        era  = zd / DAYS_PER_ERA;
        doe  = zd - era * DAYS_PER_ERA;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr   = yoe + era * 400;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        dd   = doy - (153 * mp + 2) / 5 + 1;
        mm   = (mp < 10) ? mp + 3 : mp - 9;
        if (mm <= 2)
        begin
            yr = yr + 1;
        end
        stamp.year   = yr[11:0];
        stamp.month  = mm[3:0];
        stamp.day    = dd[4:0];
        stamp.hour   = 5'(tod / SECS_PER_HOUR);
        stamp.minute = 6'((tod / 60) % 60);
        return stamp;
    endfunction

    function void note_request(logic [31:0] secs);
        due_dates.push_back(civil_from_seconds(secs));
        due_secs.push_back(secs);
    endfunction

    function int pending();
        return due_dates.size();
    endfunction

    function void check_field(string label, logic [31:0] secs, int unsigned want,
                              int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch for %0d s: expected %0d, actual %0d",
                     $time, label, secs, want, got);
            errors++;
        end
    endfunction

    function void check_result(civil_stamp_t got);
        civil_stamp_t want;
        logic [31:0]  secs;
        if (due_dates.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %0d-%0d-%0d %0d:%0d",
                     $time, got.year, got.month, got.day, got.hour, got.minute);
            errors++;
            return;
        end
        want = due_dates.pop_front();
        secs = due_secs.pop_front();
        check_field("year", secs, want.year, got.year);
        check_field("month", secs, want.month, got.month);
        check_field("day", secs, want.day, got.day);
        check_field("hour", secs, want.hour, got.hour);
        check_field("minute", secs, want.minute, got.minute);
    endfunction
endclass

module unix_seconds_to_civil_datetime_unit_tb;
    localparam int RANDOM_COUNT = 1530;
    localparam int CALM_COUNT   = 200;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [31:0] unix_seconds;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    bit          quiet;

    civil_date_ledger ledger;

    logic [31:0] directed_secs [] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd68255999, 32'd68256000, 32'd946684799, 32'd946684800,
        32'd951782400, 32'd951868799, 32'd951868800, 32'd1767225599,
        32'd2147483647, 32'd2147483648, 32'h55555555, 32'hAAAAAAAA,
        32'd4107542399, 32'd4107542400, 32'd4294944000, 32'd4294967279,
        32'd4294967280, 32'd4294967295
    };

    unix_seconds_to_civil_datetime_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .unix_seconds (unix_seconds),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .year         (year),
        .month        (month),
        .day          (day),
        .hour         (hour),
        .minute       (minute)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] random_seconds();
        longint      secs;
        longint      days;
        int unsigned mode;
        int unsigned yr;
        mode = $urandom_range(0, 19);
        if (mode < 10)
        begin
            secs = longint'($urandom);
        end
        else if (mode < 14)
        begin
            days = $urandom_range(0, 49710);
            if ($urandom_range(0, 1) == 1)
                secs = days * 86400 + 86400 - $urandom_range(1, 60);
            else
                secs = days * 86400 + $urandom_range(0, 59);
        end
        else if (mode < 17)
        begin
            yr = $urandom_range(1970, 2106);
            days = 365 * (yr - 1970) + (yr - 1969) / 4 - ((yr > 2100) ? 1 : 0);
            if ($urandom_range(0, 1) == 1)
                days = days + 59 + (((yr % 4 == 0) && (yr != 2100)) ? 1 : 0);
            secs = days * 86400 + longint'($urandom_range(0, 120)) - 60;
        end
        else if (mode < 19)
        begin
            secs = $urandom_range(0, 200000);
        end
        else
        begin
            secs = 64'hFFFF_FFFF - $urandom_range(0, 200000);
        end
        if (secs < 0)
            secs = 0;
        if (secs > 64'hFFFF_FFFF)
            secs = 64'hFFFF_FFFF;
        return secs[31:0];
    endfunction

    task automatic send_request(input logic [31:0] secs);
        unix_seconds <= secs;
        req_valid    <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        ledger.note_request(secs);
        @(negedge clk);
    endtask

    task automatic request_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            ledger.check_result('{year, month, day, hour, minute});
        end
    end

    initial
    begin
        ledger       = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        unix_seconds = 32'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_secs[i])
        begin
            request_gap();
            send_request(directed_secs[i]);
        end
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == RANDOM_COUNT - CALM_COUNT)
                quiet = 1'b1;
            request_gap();
            send_request(random_seconds());
        end
        req_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
